// File: rtl/kdsh_pkg.sv
`timescale 1ns / 1ps
// kdsh_pkg: shared types and constants for the key debounce block
// no dependencies; imported by every rtl module of the block
package kdsh_pkg;

  // event codes as they appear on the result stream
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_HOLD    = 2'd2,
    EV_RELEASE = 2'd3
  } ev_kind_t;

  // key codes, priority key 1 > key 2 > key 3
  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_1    = 2'd1,
    KEY_2    = 2'd2,
    KEY_3    = 2'd3
  } key_t;

  // debouncer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_CONFIRM = 5'b00010,
    PH_HELD    = 5'b00100,
    PH_WAIT_UP = 5'b01000,
    PH_UP_CHK  = 5'b10000
  } phase_t;

  typedef struct packed {
    ev_kind_t kind;
    key_t     key;
  } ev_t;

  typedef logic [3:0] bcd_t;

  localparam int unsigned THR_W    = 16;
  localparam int unsigned DIGITS   = 4;
  localparam logic [THR_W-1:0] HOLD_THR_RST = 16'd100;
  localparam bcd_t BCD_MAX = 4'd9;
  localparam bcd_t BCD_ZERO = 4'd0;

endpackage

// File: rtl/kdsh_debounce.sv
`timescale 1ns / 1ps
// kdsh_debounce: key pick, five-phase debouncer, hold counter and threshold register
// depends on kdsh_pkg
module kdsh_debounce (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [kdsh_pkg::THR_W-1:0] cfg_wr_data,
  input  logic                     step_en,
  input  logic [2:0]               keys,
  input  logic                     mode_all,
  output kdsh_pkg::ev_t            raw_ev
);
  import kdsh_pkg::*;

  logic [THR_W-1:0] thr_r;
  phase_t           phase_r, phase_nxt;
  key_t             latched_r, latched_nxt;
  logic [THR_W-1:0] hold_r, hold_nxt;
  logic [THR_W-1:0] hold_inc;
  key_t             code;
  ev_kind_t         kind;

  always_comb begin
    priority if (mode_all && keys[0]) begin
      code = KEY_1;
    end else if (mode_all && keys[1]) begin
      code = KEY_2;
    end else if (keys[2]) begin
      code = KEY_3;
    end else begin
      code = KEY_NONE;
    end
  end

  assign hold_inc = hold_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    latched_nxt = latched_r;
    hold_nxt    = hold_r;
    kind        = EV_NONE;
    unique case (phase_r)
      PH_IDLE: begin
        if (code != KEY_NONE) begin
          phase_nxt   = PH_CONFIRM;
          latched_nxt = code;
        end
      end
      PH_CONFIRM: begin
        if (code != KEY_NONE && code == latched_r) phase_nxt = PH_HELD;
        else phase_nxt = PH_IDLE;
      end
      PH_HELD: begin
        // any pressed key keeps the count running
        if (code != KEY_NONE) begin
          if (hold_inc > thr_r) begin
            hold_nxt  = '0;
            kind      = EV_HOLD;
            phase_nxt = PH_WAIT_UP;
          end else begin
            hold_nxt = hold_inc;
          end
        end else begin
          hold_nxt  = '0;
          kind      = EV_SHORT;
          phase_nxt = PH_WAIT_UP;
        end
      end
      PH_WAIT_UP: begin
        if (code == KEY_NONE) phase_nxt = PH_UP_CHK;
      end
      PH_UP_CHK: begin
        if (code == KEY_NONE) begin
          phase_nxt = PH_IDLE;
          hold_nxt  = '0;
          kind      = EV_RELEASE;
        end else begin
          phase_nxt = PH_WAIT_UP;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // events come only from phases that keep the latched key
  assign raw_ev.kind = kind;
  assign raw_ev.key  = latched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= HOLD_THR_RST;
      phase_r   <= PH_IDLE;
      latched_r <= KEY_NONE;
      hold_r    <= '0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (step_en) begin
        phase_r   <= phase_nxt;
        latched_r <= latched_nxt;
        hold_r    <= hold_nxt;
      end
    end
  end

endmodule

// File: rtl/kdsh_counter.sv
`timescale 1ns / 1ps
// kdsh_counter: report latch, mode toggle and four-digit bcd press counter
// depends on kdsh_pkg
module kdsh_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step_en,
  input  kdsh_pkg::ev_t                        raw_ev,
  output logic                                 mode_cur,
  output kdsh_pkg::ev_t                        ev_out,
  output logic                                 mode_nxt,
  output kdsh_pkg::bcd_t [kdsh_pkg::DIGITS-1:0] count_nxt
);
  import kdsh_pkg::*;

  logic                    allowed_r, allowed_nxt;
  logic                    mode_r;
  bcd_t [DIGITS-1:0]       count_r;
  bcd_t [DIGITS-1:0]       count_inc;
  logic                    all_nine;
  logic                    carry;
  ev_t                     ev;

  // report latch: one press event, then only its release
  always_comb begin
    allowed_nxt = allowed_r;
    ev.kind     = EV_NONE;
    ev.key      = KEY_NONE;
    if (raw_ev.kind != EV_NONE) begin
      if (allowed_r) begin
        allowed_nxt = 1'b0;
        if (raw_ev.kind == EV_SHORT || raw_ev.kind == EV_HOLD) ev = raw_ev;
      end else if (raw_ev.kind == EV_RELEASE) begin
        allowed_nxt = 1'b1;
        ev          = raw_ev;
      end
    end
  end

  // bcd increment with wrap past 9999
  always_comb begin
    all_nine = 1'b1;
    carry    = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (count_r[i] != BCD_MAX) all_nine = 1'b0;
      if (carry) begin
        if (count_r[i] == BCD_MAX) begin
          count_inc[i] = BCD_ZERO;
        end else begin
          count_inc[i] = count_r[i] + 1'b1;
          carry        = 1'b0;
        end
      end else begin
        count_inc[i] = count_r[i];
      end
    end
    if (all_nine) count_inc = '0;
  end

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    priority if (ev.kind == EV_SHORT && ev.key == KEY_3) begin
      mode_nxt = !mode_r;
    end else if (mode_r) begin
      if (ev.key == KEY_2 && (ev.kind == EV_SHORT || ev.kind == EV_HOLD)) begin
        count_nxt = count_inc;
      end else if (ev.key == KEY_1 && ev.kind == EV_HOLD) begin
        count_nxt = '0;
      end
    end
  end

  assign mode_cur = mode_r;
  assign ev_out   = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_r <= 1'b1;
      mode_r    <= 1'b0;
      count_r   <= '0;
    end else if (step_en) begin
      allowed_r <= allowed_nxt;
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// File: rtl/key_debounce_short_hold_release_top.sv
`timescale 1ns / 1ps
// path: an accepted request waits in the input register, then moves to the result register once that slot frees
// throughput: one request per cycle while out_tready is high; the input register refills as the
//   result register drains, so in_tready follows out_tready when both stages are full
// reset: rst_n synchronous active low; clears the debouncer to idle, reports allowed,
//   mode to key three only, press counter to 0, hold threshold to 100, both stages empty
// depends on kdsh_pkg, kdsh_debounce, kdsh_counter
module key_debounce_short_hold_release_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: hold threshold
  input  logic                       cfg_wr_en,
  input  logic [kdsh_pkg::THR_W-1:0] cfg_wr_data,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // key1_pressed, key2_pressed, key3_pressed, zero pad
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata   // event_kind[1:0], event_key[3:2], mode_all_keys[4],
                                                 // count_ones[8:5], count_tens[12:9],
                                                 // count_hundreds[16:13], count_thousands[20:17], pad
);
  import kdsh_pkg::*;

  // input register stage
  logic              in_valid_r;
  logic [2:0]        keys_r;
  // result register stage
  logic              out_valid_r;
  ev_t               ev_r;
  logic              mode_r;
  bcd_t [DIGITS-1:0] count_r;

  logic              advance;
  logic              step_en;
  ev_t               raw_ev;
  ev_t               ev;
  logic              mode_cur;
  logic              mode_nxt;
  bcd_t [DIGITS-1:0] count_nxt;

  // result slot frees up when empty or being taken this cycle
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  // state moves one tick each time the held request moves to the result stage
  assign step_en   = in_valid_r && advance;

  kdsh_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .keys        (keys_r),
    .mode_all    (mode_cur),   // sampling uses the mode before this tick's toggle
    .raw_ev      (raw_ev)
  );

  kdsh_counter u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .raw_ev    (raw_ev),
    .mode_cur  (mode_cur),
    .ev_out    (ev),
    .mode_nxt  (mode_nxt),
    .count_nxt (count_nxt)
  );

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) keys_r <= in_tdata[2:0];
    if (step_en) begin
      ev_r    <= ev;
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, count_r[3], count_r[2], count_r[1], count_r[0],
                       mode_r, ev_r.key, ev_r.kind};

endmodule
